FILE: hdl/soft_disk_pair_force_core_defines.svh
// assertion macros used by the checker file
`ifndef SOFT_DISK_PAIR_FORCE_CORE_DEFINES_SVH
`define SOFT_DISK_PAIR_FORCE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define SDPF_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define SDPF_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/sdpf_pkg.sv
`default_nettype none

package sdpf_pkg;

  localparam int POS_FRAC    = 24;
  localparam int STRAIN_FRAC = 28;
  localparam int TERM_FRAC   = 48;

  localparam int FORCE_SHIFT   = 2 * POS_FRAC + 1;
  localparam int ENERGY_SHIFT  = TERM_FRAC - 1;
  localparam int VIRIAL_SHIFT  = 2 * POS_FRAC + TERM_FRAC;

  localparam int ROOT_W = 27;   // root of the squared distance
  localparam int SQ_W   = 2 * ROOT_W;

  localparam int XW    = 176;   // divider numerator
  localparam int DW    = 143;   // divider denominator
  localparam int QW    = 47;    // quotient bits, saturating
  localparam int LANES = 5;

  localparam int LANE_FX = 0;
  localparam int LANE_FY = 1;
  localparam int LANE_EN = 2;
  localparam int LANE_PR = 3;
  localparam int LANE_ST = 4;

  localparam int FORCE_W = 32;
  localparam logic [FORCE_W-2:0] FORCE_MAX = '1;

  localparam logic [30:0] LEN_RESET   = 31'd691892388;
  localparam logic [15:0] COUNT_RESET = 16'd1024;

  typedef enum logic [1:0] {
    CFG_STRAIN = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_COUNT  = 2'd2
  } cfg_idx_t;

  // side data riding along the root pipeline
  typedef struct packed {
    logic              contact;
    logic              negx;
    logic              negy;
    logic [25:0]       ax;
    logic [25:0]       ay;
    logic [26:0]       s;
    logic [SQ_W-1:0]   s2;
  } rt_tag_t;

  // side data riding along the divider pipeline
  typedef struct packed {
    logic contact;
    logic negx;
    logic negy;
    logic dpos;
    logic lpos;
  } div_tag_t;

endpackage

`default_nettype wire

FILE: hdl/sdpf_channels.sv
`default_nettype none

interface sdpf_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] own_x;
  logic signed [31:0] own_y;
  logic signed [31:0] neighbor_x;
  logic signed [31:0] neighbor_y;
  logic [25:0]        own_diameter;
  logic [25:0]        neighbor_diameter;

  modport source (output valid, own_x, own_y, neighbor_x, neighbor_y,
                  own_diameter, neighbor_diameter, input ready);
  modport sink   (input valid, own_x, own_y, neighbor_x, neighbor_y,
                  own_diameter, neighbor_diameter, output ready);
endinterface

interface sdpf_result_if;
  logic               valid;
  logic               ready;
  logic               in_contact;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic [46:0]        energy_term;
  logic signed [47:0] pressure_term;
  logic signed [47:0] stress_term;

  modport source (output valid, in_contact, force_x, force_y, energy_term,
                  pressure_term, stress_term, input ready);
  modport sink   (input valid, in_contact, force_x, force_y, energy_term,
                  pressure_term, stress_term, output ready);
endinterface

`default_nettype wire

FILE: hdl/soft_disk_pair_force_core.sv
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  pair     | in  | valid / ready | own_x own_y neighbor_x neighbor_y, diameters
//  result   | out | valid / ready | in_contact force_x force_y energy/pressure/stress
//  cfg      | in  | cfg_write     | cfg_index, cfg_data (no read-back)
//
//  one pair transfer per clock when result side keeps up
//  depth set by the 27-stage root pipeline and the 48-stage divider lanes
//  rst is synchronous, clears valid bits, output and skid stage, config registers
//  a stalled result parks in a skid stage; pair.ready drops only once it is full
`default_nettype none

module soft_disk_pair_force_core import sdpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  sdpf_pair_if.sink            pair,
  sdpf_result_if.source        result,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int SLD_CHUNK = 29;  // chunk of s2*L^2 per partial product

  typedef struct packed {
    logic               in_contact;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [46:0]        energy_term;
    logic signed [47:0] pressure_term;
    logic signed [47:0] stress_term;
  } res_t;

  // ---------------------------------------------------------------------------
  // configuration registers and values derived from them
  // ---------------------------------------------------------------------------
  logic signed [31:0] shear_strain;
  logic [30:0]        box_length;
  logic [15:0]        particle_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      shear_strain   <= '0;
      box_length     <= LEN_RESET;
      particle_count <= COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STRAIN: shear_strain   <= cfg_data;
        CFG_LENGTH: box_length     <= cfg_data[30:0];
        CFG_COUNT:  particle_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // L*g and L^2 are registered, following the registers in the next cycle
  logic signed [62:0] strain_prod;
  logic [61:0]        box_sq;
  logic signed [34:0] shift_h;
  logic [15:0]        count_eff;

  always_ff @(posedge clk) begin
    strain_prod <= $signed({1'b0, box_length}) * shear_strain;
    box_sq      <= box_length * box_length;
  end

  // floor(L*g / 2^28) is the arithmetic top slice
  assign shift_h   = strain_prod[62:STRAIN_FRAC];
  assign count_eff = (particle_count == '0) ? 16'd1 : particle_count;

  // ---------------------------------------------------------------------------
  // global advance: the whole pipe moves while the skid stage is empty
  // ---------------------------------------------------------------------------
  logic adv;
  logic sk_v;

  assign adv        = !sk_v;
  assign pair.ready = adv;

  // stage a: raw differences and diameter sum
  logic               a_v;
  logic signed [32:0] a_dx, a_dy;
  logic [26:0]        a_s;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= pair.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx <= 33'(pair.own_x) - 33'(pair.neighbor_x);
      a_dy <= 33'(pair.own_y) - 33'(pair.neighbor_y);
      a_s  <= 27'(pair.own_diameter) + 27'(pair.neighbor_diameter);
    end
  end

  // stage b: y wrap, which also slides x by the shear offset
  logic signed [34:0] len_s;
  logic signed [34:0] dy_dbl;
  logic signed [33:0] dy_b_next;
  logic signed [36:0] dx_b_next;
  logic               b_v;
  logic signed [33:0] b_dy;
  logic signed [36:0] b_dx;
  logic [26:0]        b_s;

  assign len_s  = $signed({4'b0, box_length});
  assign dy_dbl = $signed({a_dy[32], a_dy, 1'b0});

  always_comb begin
    dy_b_next = 34'(a_dy);
    dx_b_next = 37'(a_dx);
    if (dy_dbl > len_s) begin
      dy_b_next = 34'(a_dy) - 34'(len_s);
      dx_b_next = 37'(a_dx) - 37'(shift_h);
    end else if (dy_dbl < -len_s) begin
      dy_b_next = 34'(a_dy) + 34'(len_s);
      dx_b_next = 37'(a_dx) + 37'(shift_h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_dy <= dy_b_next;
      b_dx <= dx_b_next;
      b_s  <= a_s;
    end
  end

  // stage c: x wrap, magnitudes, far-pair test
  logic signed [37:0] dx_dbl;
  logic signed [37:0] len_x;
  logic signed [37:0] dx_c;
  logic [37:0]        ax_full;
  logic [33:0]        ay_full;
  logic               c_v, c_far, c_negx, c_negy;
  logic [25:0]        c_ax, c_ay;
  logic [26:0]        c_s;

  assign dx_dbl = $signed({b_dx, 1'b0});
  assign len_x  = 38'(len_s);

  always_comb begin
    dx_c = 38'(b_dx);
    if (dx_dbl > len_x) dx_c = 38'(b_dx) - len_x;
    else if (dx_dbl < -len_x) dx_c = 38'(b_dx) + len_x;
  end

  assign ax_full = dx_c[37] ? 38'(-dx_c) : 38'(dx_c);
  assign ay_full = b_dy[33] ? 34'(-b_dy) : 34'(b_dy);

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_far  <= (|ax_full[37:26]) || (|ay_full[33:26]);
      c_ax   <= ax_full[25:0];
      c_ay   <= ay_full[25:0];
      c_negx <= dx_c[37];
      c_negy <= b_dy[33];
      c_s    <= b_s;
    end
  end

  // stage d: squares
  logic              d_v, d_far, d_negx, d_negy;
  logic [51:0]       d_ax2, d_ay2;
  logic [SQ_W-1:0]   d_s2;
  logic [25:0]       d_ax, d_ay;
  logic [26:0]       d_s;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= c_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ax2  <= c_ax * c_ax;
      d_ay2  <= c_ay * c_ay;
      d_s2   <= c_s * c_s;
      d_ax   <= c_ax;
      d_ay   <= c_ay;
      d_s    <= c_s;
      d_far  <= c_far;
      d_negx <= c_negx;
      d_negy <= c_negy;
    end
  end

  // stage e: squared distance and exact overlap test 4*r^2 < s^2
  logic [52:0]     dr2_e;
  logic            e_v;
  logic [52:0]     e_dr2;
  rt_tag_t         e_tag;

  assign dr2_e = 53'(d_ax2) + 53'(d_ay2);

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= d_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_dr2         <= dr2_e;
      e_tag.contact <= !d_far && ({dr2_e, 2'b00} < 55'(d_s2));
      e_tag.negx    <= d_negx;
      e_tag.negy    <= d_negy;
      e_tag.ax      <= d_ax;
      e_tag.ay      <= d_ay;
      e_tag.s       <= d_s;
      e_tag.s2      <= d_s2;
    end
  end

  // root pipeline: d = floor(sqrt(dr2))
  logic              rt_v;
  logic [ROOT_W-1:0] rt_root;
  rt_tag_t           rt_tag;

  sdpf_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (e_v),
    .radicand  (SQ_W'(e_dr2)),
    .in_tag    (e_tag),
    .out_valid (rt_v),
    .root      (rt_root),
    .out_tag   (rt_tag)
  );

  // stage g: overlap m = s - 2d and all first-level partial products
  logic [26:0]            rt_m;
  logic                   g_v;
  logic [52:0]            g_mx, g_my;
  logic [53:0]            g_mm, g_dm;
  logic [51:0]            g_axy;
  logic [26:0]            g_m;
  logic [ROOT_W-1:0]      g_d;
  logic [1:0][53:0]       g_sdp;
  logic [1:0][42:0]       g_snp;
  logic [3:0][57:0]       g_slp;
  div_tag_t               g_tag;

  assign rt_m = 27'(28'(rt_tag.s) - {rt_root, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (adv) g_v <= rt_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_mx     <= rt_m * rt_tag.ax;
      g_my     <= rt_m * rt_tag.ay;
      g_mm     <= rt_m * rt_m;
      g_dm     <= rt_root * rt_m;
      g_axy    <= rt_tag.ax * rt_tag.ay;
      g_m      <= rt_m;
      g_d      <= rt_root;
      g_sdp[0] <= rt_tag.s2[26:0] * rt_root;
      g_sdp[1] <= rt_tag.s2[53:27] * rt_root;
      g_snp[0] <= rt_tag.s2[26:0] * count_eff;
      g_snp[1] <= rt_tag.s2[53:27] * count_eff;
      g_slp[0] <= rt_tag.s2[26:0] * box_sq[30:0];
      g_slp[1] <= rt_tag.s2[26:0] * box_sq[61:31];
      g_slp[2] <= rt_tag.s2[53:27] * box_sq[30:0];
      g_slp[3] <= rt_tag.s2[53:27] * box_sq[61:31];
      g_tag.contact <= rt_tag.contact;
      g_tag.negx    <= rt_tag.negx;
      g_tag.negy    <= rt_tag.negy;
      g_tag.dpos    <= |rt_root;
      g_tag.lpos    <= |box_length;
    end
  end

  // stage h: sum partials of s2*d, s2*N, s2*L^2; split |dx|*|dy|*m
  logic              h_v;
  logic [52:0]       h_mx, h_my;
  logic [53:0]       h_mm, h_dm;
  logic [ROOT_W-1:0] h_d;
  logic [1:0][52:0]  h_axymp;
  logic [80:0]       h_sd;
  logic [69:0]       h_sn;
  logic [115:0]      h_sl;
  div_tag_t          h_tag;

  always_ff @(posedge clk) begin
    if (rst) h_v <= 1'b0;
    else if (adv) h_v <= g_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_mx       <= g_mx;
      h_my       <= g_my;
      h_mm       <= g_mm;
      h_dm       <= g_dm;
      h_d        <= g_d;
      h_axymp[0] <= g_axy[25:0] * g_m;
      h_axymp[1] <= g_axy[51:26] * g_m;
      h_sd       <= 81'(g_sdp[0]) + {g_sdp[1], 27'b0};
      h_sn       <= 70'(g_snp[0]) + {g_snp[1], 27'b0};
      h_sl       <= 116'(g_slp[0]) + (116'(g_slp[1]) << 31)
                  + (116'(g_slp[2]) << 27) + (116'(g_slp[3]) << 58);
      h_tag      <= g_tag;
    end
  end

  // stage i: stress numerator sum; partials of s2*L^2*d
  logic              i_v;
  logic [52:0]       i_mx, i_my;
  logic [53:0]       i_mm, i_dm;
  logic [78:0]       i_axym;
  logic [80:0]       i_sd;
  logic [69:0]       i_sn;
  logic [115:0]      i_sl;
  logic [3:0][55:0]  i_sldp;
  div_tag_t          i_tag;

  always_ff @(posedge clk) begin
    if (rst) i_v <= 1'b0;
    else if (adv) i_v <= h_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_mx   <= h_mx;
      i_my   <= h_my;
      i_mm   <= h_mm;
      i_dm   <= h_dm;
      i_axym <= 79'(h_axymp[0]) + {h_axymp[1], 26'b0};
      i_sd   <= h_sd;
      i_sn   <= h_sn;
      i_sl   <= h_sl;
      for (int c = 0; c < 4; c++) begin
        i_sldp[c] <= h_sl[c*SLD_CHUNK +: SLD_CHUNK] * h_d;
      end
      i_tag  <= h_tag;
    end
  end

  // stage j: full stress denominator; divider operands
  logic              j_v;
  logic [52:0]       j_mx, j_my;
  logic [53:0]       j_mm, j_dm;
  logic [78:0]       j_axym;
  logic [80:0]       j_sd;
  logic [69:0]       j_sn;
  logic [115:0]      j_sl;
  logic [DW-1:0]     j_sld;
  div_tag_t          j_tag;

  always_ff @(posedge clk) begin
    if (rst) j_v <= 1'b0;
    else if (adv) j_v <= i_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_mx   <= i_mx;
      j_my   <= i_my;
      j_mm   <= i_mm;
      j_dm   <= i_dm;
      j_axym <= i_axym;
      j_sd   <= i_sd;
      j_sn   <= i_sn;
      j_sl   <= i_sl;
      j_sld  <= DW'(i_sldp[0]) + (DW'(i_sldp[1]) << SLD_CHUNK)
              + (DW'(i_sldp[2]) << (2 * SLD_CHUNK))
              + (DW'(i_sldp[3]) << (3 * SLD_CHUNK));
      j_tag  <= i_tag;
    end
  end

  // divider lanes: force x, force y, energy, pressure, stress
  logic [LANES-1:0][XW-1:0] dv_num;
  logic [LANES-1:0][DW-1:0] dv_den;
  logic                     dv_v;
  logic [LANES-1:0][QW-1:0] dv_q;
  div_tag_t                 dv_tag;

  always_comb begin
    dv_num[LANE_FX] = XW'(j_mx) << FORCE_SHIFT;
    dv_num[LANE_FY] = XW'(j_my) << FORCE_SHIFT;
    dv_num[LANE_EN] = XW'(j_mm) << ENERGY_SHIFT;
    dv_num[LANE_PR] = XW'(j_dm) << VIRIAL_SHIFT;
    dv_num[LANE_ST] = XW'(j_axym) << VIRIAL_SHIFT;
    dv_den[LANE_FX] = DW'(j_sd);
    dv_den[LANE_FY] = DW'(j_sd);
    dv_den[LANE_EN] = DW'(j_sn);
    dv_den[LANE_PR] = DW'(j_sl);
    dv_den[LANE_ST] = j_sld;
  end

  sdpf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (j_v),
    .num       (dv_num),
    .den       (dv_den),
    .in_tag    (j_tag),
    .out_valid (dv_v),
    .quo       (dv_q),
    .out_tag   (dv_tag)
  );

  // result formatting: force clamp, signs, zero when a guard fails
  logic [FORCE_W-2:0] fx_mag, fy_mag;
  res_t               fin;

  assign fx_mag = (dv_q[LANE_FX] > QW'(FORCE_MAX)) ? FORCE_MAX
                                                   : dv_q[LANE_FX][FORCE_W-2:0];
  assign fy_mag = (dv_q[LANE_FY] > QW'(FORCE_MAX)) ? FORCE_MAX
                                                   : dv_q[LANE_FY][FORCE_W-2:0];

  always_comb begin
    fin               = '0;
    fin.in_contact    = dv_tag.contact;
    if (dv_tag.contact) begin
      fin.energy_term = dv_q[LANE_EN];
      if (dv_tag.dpos) begin
        fin.force_x = dv_tag.negx ? -32'(fx_mag) : 32'(fx_mag);
        fin.force_y = dv_tag.negy ? -32'(fy_mag) : 32'(fy_mag);
      end
      if (dv_tag.lpos) begin
        fin.pressure_term = 48'(dv_q[LANE_PR]);
        if (dv_tag.dpos) begin
          fin.stress_term = (dv_tag.negx != dv_tag.negy) ? -48'(dv_q[LANE_ST])
                                                         : 48'(dv_q[LANE_ST]);
        end
      end
    end
  end

  // output register plus skid stage
  logic out_v;
  res_t out_d, sk_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (sk_v) begin
      if (result.ready) sk_v <= 1'b0;
    end else if (!out_v || result.ready) begin
      out_v <= dv_v;
    end else if (dv_v) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v) begin
      if (result.ready) out_d <= sk_d;
    end else if (!out_v || result.ready) begin
      out_d <= fin;
    end else begin
      sk_d <= fin;
    end
  end

  assign result.valid         = out_v;
  assign result.in_contact    = out_d.in_contact;
  assign result.force_x       = out_d.force_x;
  assign result.force_y       = out_d.force_y;
  assign result.energy_term   = out_d.energy_term;
  assign result.pressure_term = out_d.pressure_term;
  assign result.stress_term   = out_d.stress_term;

endmodule

`default_nettype wire

FILE: hdl/sdpf_isqrt.sv
`default_nettype none

// pipelined integer square root, one root bit per stage
module sdpf_isqrt import sdpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   radicand,
  input  rt_tag_t           in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output rt_tag_t           out_tag
);

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] vld;
  logic [SQ_W-1:0]   rad  [ROOT_W-1];
  logic [REM_W-1:0]  rem  [ROOT_W-1];
  logic [ROOT_W-1:0] rt   [ROOT_W];
  rt_tag_t           tag  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [SQ_W-1:0]    src_rad;
    logic [REM_W-1:0]   src_rem;
    logic [ROOT_W-1:0]  src_rt;
    logic               src_v;
    rt_tag_t            src_tag;
    logic [REM_W+1:0]   cand;
    logic [REM_W+1:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign src_rad = radicand;
      assign src_rem = '0;
      assign src_rt  = '0;
      assign src_v   = in_valid;
      assign src_tag = in_tag;
    end else begin : g_next
      assign src_rad = rad[k-1];
      assign src_rem = rem[k-1];
      assign src_rt  = rt[k-1];
      assign src_v   = vld[k-1];
      assign src_tag = tag[k-1];
    end

    assign cand  = {src_rem, src_rad[SQ_W-1 -: 2]};
    assign trial = (REM_W+2)'({src_rt, 2'b01});
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt[k]  <= {src_rt[ROOT_W-2:0], ge};
        tag[k] <= src_tag;
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rad[k] <= src_rad << 2;
          rem[k] <= ge ? REM_W'(cand - trial) : REM_W'(cand);
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign out_tag   = tag[ROOT_W-1];

endmodule

`default_nettype wire

FILE: hdl/sdpf_div.sv
`default_nettype none

// pipelined restoring divider, several lanes in lockstep, saturating quotient
module sdpf_div import sdpf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [LANES-1:0][XW-1:0]   num,
  input  logic [LANES-1:0][DW-1:0]   den,
  input  div_tag_t                   in_tag,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   quo,
  output div_tag_t                   out_tag
);

  logic [QW:0]      vld;
  div_tag_t         tag [QW+1];
  logic [DW-1:0]    dn  [QW][LANES];
  logic [DW-1:0]    rem [QW][LANES];
  logic [QW-1:0]    low [QW][LANES];
  logic [QW-1:0]    qb  [QW+1][LANES];
  logic             ovf [QW+1][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= in_tag;
      for (int k = 1; k <= QW; k++) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [XW-QW-1:0] head;
    logic             pre_ovf;

    // quotient reaches 2^QW exactly when the top part is not below den
    assign head    = num[l][XW-1:QW];
    assign pre_ovf = DW'(head) >= den[l];

    always_ff @(posedge clk) begin
      if (adv) begin
        dn[0][l]  <= den[l];
        rem[0][l] <= pre_ovf ? '0 : DW'(head);
        low[0][l] <= num[l][QW-1:0];
        qb[0][l]  <= '0;
        ovf[0][l] <= pre_ovf;
      end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DW:0] trial;
      logic        ge;

      assign trial = {rem[k-1][l], low[k-1][l][QW-1]};
      assign ge    = trial >= {1'b0, dn[k-1][l]};

      always_ff @(posedge clk) begin
        if (adv) begin
          qb[k][l]  <= {qb[k-1][l][QW-2:0], ge};
          ovf[k][l] <= ovf[k-1][l];
        end
      end

      if (k < QW) begin : g_carry
        always_ff @(posedge clk) begin
          if (adv) begin
            dn[k][l]  <= dn[k-1][l];
            rem[k][l] <= ge ? DW'(trial - {1'b0, dn[k-1][l]}) : DW'(trial);
            low[k][l] <= {low[k-1][l][QW-2:0], 1'b0};
          end
        end
      end
    end

    assign quo[l] = ovf[QW][l] ? '1 : qb[QW][l];
  end

  assign out_valid = vld[QW];
  assign out_tag   = tag[QW];

endmodule

`default_nettype wire

FILE: hdl/sdpf_checker.sv
`default_nettype none
`include "soft_disk_pair_force_core_defines.svh"

module sdpf_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic               in_contact,
  input logic signed [31:0] force_x,
  input logic signed [31:0] force_y,
  input logic [46:0]        energy_term,
  input logic signed [47:0] pressure_term,
  input logic signed [47:0] stress_term
);

  // a pair out of contact carries no force or term
  `SDPF_ASSERT_IMP(a_no_contact_zero, res_valid && !in_contact, force_x == 0 && force_y == 0 && energy_term == 0 && pressure_term == 0 && stress_term == 0, "nonzero result without contact")

  // pressure share is never negative
  `SDPF_ASSERT_IMP(a_pressure_sign, res_valid, !pressure_term[47], "negative pressure term")

  // force saturates symmetrically, so the most negative code never shows
  `SDPF_ASSERT_IMP(a_force_range, res_valid, force_x != 32'sh8000_0000 && force_y != 32'sh8000_0000, "force outside saturation range")

  // a stalled result holds
  `SDPF_ASSERT_NXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(force_x) && $stable(stress_term), "stalled result changed")

endmodule

bind soft_disk_pair_force_core sdpf_checker u_sdpf_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .in_contact    (result.in_contact),
  .force_x       (result.force_x),
  .force_y       (result.force_y),
  .energy_term   (result.energy_term),
  .pressure_term (result.pressure_term),
  .stress_term   (result.stress_term)
);

`default_nettype wire
